FILE: hw/rtl/assert_macros.svh
// assertion helpers used by ftrb_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check, sampled on the clock, off during reset
`define FTRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition this cycle implies consequence next cycle
`define FTRB_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ftrb_pkg.sv
// ----------------------------------------------------------------------------
// ftrb_pkg
// Widths, codes, command and status types of the trace ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrb_pkg;

    localparam int RECORD_DEPTH   = 32;
    localparam int FILTER_ENTRIES = 32;

    localparam int ACT_W   = 3;
    localparam int PID_W   = 23;
    localparam int STATE_W = 16;
    localparam int EXIT_W  = 6;
    localparam int NAME_W  = 64;
    localparam int TOTAL_W = 63;

    localparam int RA_W = $clog2(RECORD_DEPTH);
    localparam int RC_W = $clog2(RECORD_DEPTH + 1);
    localparam int FA_W = $clog2(FILTER_ENTRIES);
    localparam int FC_W = $clog2(FILTER_ENTRIES + 1);

    localparam logic [ACT_W-1:0] ACT_RECORD  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

    localparam logic [EXIT_W-1:0] EXIT_DEAD   = 6'd16;
    localparam logic [EXIT_W-1:0] EXIT_ZOMBIE = 6'd32;

    localparam logic [PID_W-1:0] PID_ALL = '1;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [STATE_W-1:0] state;
        logic [NAME_W-1:0]  name_low;
        logic [NAME_W-1:0]  name_high;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic ready;
        logic mode_set;
        logic scan_start;
        logic f_step;
        logic f_hit;
        logic f_rd_next;
        logic sh_zero;
        logic sh_wr;
        logic f_dec;
        logic f_add;
        logic rec_wr;
        logic ring_clear;
        logic k_start;
        logic c_step;
        logic c_done;
        logic r_step;
        logic r_end;
    } t_cmd;

    typedef struct packed {
        logic             in_valid;
        logic [ACT_W-1:0] action;
        logic             pid_all;
        logic             pid_neg;
        logic             f_match;
        logic             i_end;
        logic             i1_end;
        logic             found;
        logic             mode_eq;
        logic             exclude;
        logic             full;
        logic             ring_empty;
        logic             k_last;
        logic             rec_match;
        logic             pend_v;
        logic             out_busy;
    } t_stat;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_DISP = 15'b000000000000010,
        S_FRD  = 15'b000000000000100,
        S_FCHK = 15'b000000000001000,
        S_FDEC = 15'b000000000010000,
        S_SRD  = 15'b000000000100000,
        S_SWR  = 15'b000000001000000,
        S_ADD  = 15'b000000010000000,
        S_REC  = 15'b000000100000000,
        S_RRD  = 15'b000001000000000,
        S_RCHK = 15'b000010000000000,
        S_REND = 15'b000100000000000,
        S_CRD  = 15'b001000000000000,
        S_CCHK = 15'b010000000000000,
        S_CEND = 15'b100000000000000
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/ftrb_if.sv
// ----------------------------------------------------------------------------
// ftrb_if
// Request and result channels of the trace ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftrb_in_if;
    import ftrb_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic signed [PID_W-1:0] pid;
    logic [STATE_W-1:0]  task_state;
    logic [EXIT_W-1:0]   exit_code_state;
    logic [NAME_W-1:0]   name_low;
    logic [NAME_W-1:0]   name_high;

    modport source (output valid, action, pid, task_state, exit_code_state,
                    name_low, name_high, input ready);
    modport sink   (input valid, action, pid, task_state, exit_code_state,
                    name_low, name_high, output ready);
endinterface

interface ftrb_out_if;
    import ftrb_pkg::*;
    logic                valid;
    logic                ready;
    logic                has_record;
    logic signed [PID_W-1:0] rec_pid;
    logic [STATE_W-1:0]  rec_state;
    logic [NAME_W-1:0]   rec_name_low;
    logic [NAME_W-1:0]   rec_name_high;
    logic                last;
    logic [TOTAL_W-1:0]  total_seen;

    modport source (output valid, has_record, rec_pid, rec_state, rec_name_low,
                    rec_name_high, last, total_seen, input ready);
    modport sink   (input valid, has_record, rec_pid, rec_state, rec_name_low,
                    rec_name_high, last, total_seen, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ftrb_ram.sv
// ----------------------------------------------------------------------------
// ftrb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrb_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

FILE: hw/rtl/ftrb_ctrl.sv
// ----------------------------------------------------------------------------
// ftrb_ctrl
// Sequencer: filter search and shift, ring append, read stream, compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ftrb_pkg::t_stat i_stat,
    output ftrb_pkg::t_cmd      o_cmd
);
    import ftrb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_stat.in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                unique case (i_stat.action)
                    ACT_RECORD: begin
                        if (i_stat.pid_neg) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_FRD;
                        end
                    end
                    ACT_ENABLE, ACT_DISABLE: begin
                        if (i_stat.pid_all) begin
                            o_cmd.mode_set = 1'b1;
                            n_state = S_IDLE;
                        end else if (i_stat.pid_neg) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_FRD;
                        end
                    end
                    ACT_READ: begin
                        o_cmd.k_start = 1'b1;
                        if ((i_stat.pid_neg && !i_stat.pid_all) || i_stat.ring_empty) begin
                            n_state = S_REND;
                        end else begin
                            n_state = S_RRD;
                        end
                    end
                    ACT_CLEAR: begin
                        if (i_stat.pid_all) begin
                            o_cmd.ring_clear = 1'b1;
                            n_state = S_IDLE;
                        end else if (i_stat.pid_neg) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.k_start = 1'b1;
                            n_state = i_stat.ring_empty ? S_CEND : S_CRD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FRD: begin
                n_state = i_stat.i_end ? S_FDEC : S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.f_match) begin
                    o_cmd.f_hit = 1'b1;
                    n_state = S_FDEC;
                end else begin
                    o_cmd.f_step = 1'b1;
                    n_state = S_FRD;
                end
            end
            S_FDEC: begin
                if (i_stat.action == ACT_RECORD) begin
                    // listed in exclude mode or unlisted in include mode drops it
                    n_state = (i_stat.found == i_stat.exclude) ? S_IDLE : S_REC;
                end else if (i_stat.mode_eq) begin
                    n_state = i_stat.found ? S_SRD : S_IDLE;
                end else if (i_stat.found) begin
                    n_state = S_IDLE;
                end else if (i_stat.full) begin
                    o_cmd.sh_zero = 1'b1;
                    n_state = S_SRD;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_SRD: begin
                o_cmd.f_rd_next = 1'b1;
                if (i_stat.i1_end) begin
                    o_cmd.f_dec = 1'b1;
                    n_state = i_stat.mode_eq ? S_IDLE : S_ADD;
                end else begin
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.f_rd_next = 1'b1;
                o_cmd.sh_wr = 1'b1;
                n_state = S_SRD;
            end
            S_ADD: begin
                o_cmd.f_add = 1'b1;
                n_state = S_IDLE;
            end
            S_REC: begin
                o_cmd.rec_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_RRD: n_state = S_RCHK;
            S_RCHK: begin
                // hold while a second match waits for the output word to drain
                if (!(i_stat.rec_match && i_stat.pend_v && i_stat.out_busy)) begin
                    o_cmd.r_step = 1'b1;
                    n_state = i_stat.k_last ? S_REND : S_RRD;
                end
            end
            S_REND: begin
                if (!i_stat.out_busy) begin
                    o_cmd.r_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CRD: n_state = S_CCHK;
            S_CCHK: begin
                o_cmd.c_step = 1'b1;
                n_state = i_stat.k_last ? S_CEND : S_CRD;
            end
            S_CEND: begin
                o_cmd.c_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

`default_nettype wire

FILE: hw/rtl/ftrb_dp.sv
// ----------------------------------------------------------------------------
// ftrb_dp
// Datapath: request latch, filter list RAM, record ring RAM, counters,
// pending record and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ftrb_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ftrb_pkg::t_cmd  i_cmd,
    output ftrb_pkg::t_stat      o_stat,
    ftrb_in_if.sink              i_in,
    ftrb_out_if.source           o_out
);
    import ftrb_pkg::*;

    function automatic logic [RA_W-1:0] slot_of(input logic [RA_W-1:0] h,
                                                 input logic [RC_W-1:0] x);
        logic [RC_W:0] s;
        s = {{(RC_W+1-RA_W){1'b0}}, h} + {1'b0, x};
        if (s >= (RC_W+1)'(RECORD_DEPTH)) s = s - (RC_W+1)'(RECORD_DEPTH);
        return s[RA_W-1:0];
    endfunction

    // request latch
    logic [ACT_W-1:0]   r_act;
    logic [PID_W-1:0]   r_pid;
    logic [STATE_W-1:0] r_task;
    logic [EXIT_W-1:0]  r_exit;
    logic [NAME_W-1:0]  r_nlo, r_nhi;

    logic               r_exclude;
    logic [FC_W-1:0]    r_used, r_i;
    logic               r_found;
    logic [RA_W-1:0]    r_head;
    logic [RC_W-1:0]    r_count, r_k, r_w;
    logic [TOTAL_W-1:0] r_total;
    logic               r_pend_v;
    t_rec               r_pend;
    logic               r_ovalid, r_has, r_last;
    t_rec               r_out;
    logic [TOTAL_W-1:0] r_otot;

    logic               acc, to_excl, ring_full, keep, rec_match, out_busy;
    logic [PID_W-1:0]   f_rd;
    t_rec               rg_rd, rec_new;
    logic [FC_W:0]      i_plus;
    logic               f_we, g_we;
    logic [FA_W-1:0]    f_waddr, f_raddr;
    logic [PID_W-1:0]   f_wdata;
    logic [RA_W-1:0]    g_waddr, g_raddr;
    t_rec               g_wdata;

    assign acc       = i_in.valid & i_cmd.ready;
    assign i_in.ready = i_cmd.ready;
    assign to_excl   = (r_act == ACT_ENABLE);
    assign ring_full = (r_count == RC_W'(RECORD_DEPTH));
    assign keep      = (rg_rd.pid != r_pid);
    assign rec_match = (r_pid == PID_ALL) || (rg_rd.pid == r_pid);
    assign out_busy  = r_ovalid & ~o_out.ready;
    assign i_plus    = {1'b0, r_i} + 1'b1;

    always_comb begin
        rec_new.pid       = r_pid;
        rec_new.state     = (r_exit == EXIT_DEAD || r_exit == EXIT_ZOMBIE)
                            ? {{(STATE_W-EXIT_W){1'b0}}, r_exit} : r_task;
        rec_new.name_low  = r_nlo;
        rec_new.name_high = r_nhi;
    end

    // filter list memory
    assign f_raddr = i_cmd.f_rd_next ? i_plus[FA_W-1:0] : r_i[FA_W-1:0];
    assign f_we    = i_cmd.sh_wr | i_cmd.f_add;
    assign f_waddr = i_cmd.f_add ? r_used[FA_W-1:0] : r_i[FA_W-1:0];
    assign f_wdata = i_cmd.f_add ? r_pid : f_rd;

    ftrb_ram #(.W(PID_W), .D(FILTER_ENTRIES)) u_filt (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rd)
    );

    // record ring memory
    assign g_raddr = slot_of(r_head, r_k);
    assign g_we    = i_cmd.rec_wr | (i_cmd.c_step & keep & (r_w != r_k));
    assign g_waddr = i_cmd.rec_wr ? (ring_full ? r_head : slot_of(r_head, r_count))
                                  : slot_of(r_head, r_w);
    assign g_wdata = i_cmd.rec_wr ? rec_new : rg_rd;

    ftrb_ram #(.W(REC_W), .D(RECORD_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (rg_rd)
    );

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act  <= i_in.action;
            r_pid  <= i_in.pid;
            r_task <= i_in.task_state;
            r_exit <= i_in.exit_code_state;
            r_nlo  <= i_in.name_low;
            r_nhi  <= i_in.name_high;
        end
        if (i_cmd.scan_start || i_cmd.sh_zero) r_i <= '0;
        else if (i_cmd.f_step || i_cmd.sh_wr) r_i <= i_plus[FC_W-1:0];
        if (i_cmd.scan_start) r_found <= 1'b0;
        else if (i_cmd.f_hit) r_found <= 1'b1;
        if (i_cmd.k_start) begin
            r_k <= '0;
            r_w <= '0;
        end else begin
            if (i_cmd.c_step || i_cmd.r_step) r_k <= r_k + 1'b1;
            if (i_cmd.c_step && keep) r_w <= r_w + 1'b1;
        end
        if (i_cmd.r_step && rec_match) r_pend <= rg_rd;
        if ((i_cmd.r_step && rec_match && r_pend_v) || i_cmd.r_end) begin
            r_has <= i_cmd.r_end ? r_pend_v : 1'b1;
            r_out <= (i_cmd.r_end && !r_pend_v) ? '0 : r_pend;
            r_last <= i_cmd.r_end;
            // total is held with the word so later requests cannot change it
            r_otot <= r_total;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exclude <= 1'b0;
            r_used    <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_pend_v  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.mode_set) begin
                r_exclude <= to_excl;
                r_used    <= '0;
            end else if (i_cmd.f_dec) begin
                r_used <= r_used - 1'b1;
            end else if (i_cmd.f_add) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.rec_wr) begin
                r_total <= r_total + 1'b1;
                if (!ring_full) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_head <= (r_head == RA_W'(RECORD_DEPTH - 1)) ? '0 : r_head + 1'b1;
                end
            end else if (i_cmd.ring_clear) begin
                r_count <= '0;
                r_head  <= '0;
            end else if (i_cmd.c_done) begin
                r_count <= r_w;
                if (r_w == '0) r_head <= '0;
            end
            if (i_cmd.k_start || i_cmd.r_end) r_pend_v <= 1'b0;
            else if (i_cmd.r_step && rec_match) r_pend_v <= 1'b1;
            if ((i_cmd.r_step && rec_match && r_pend_v) || i_cmd.r_end) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.has_record    = r_has;
    assign o_out.rec_pid       = r_out.pid;
    assign o_out.rec_state     = r_out.state;
    assign o_out.rec_name_low  = r_out.name_low;
    assign o_out.rec_name_high = r_out.name_high;
    assign o_out.last          = r_last;
    assign o_out.total_seen    = r_otot;

    always_comb begin
        o_stat.in_valid   = i_in.valid;
        o_stat.action     = r_act;
        o_stat.pid_all    = (r_pid == PID_ALL);
        o_stat.pid_neg    = r_pid[PID_W-1];
        o_stat.f_match    = (f_rd == r_pid);
        o_stat.i_end      = (r_i == r_used);
        o_stat.i1_end     = (i_plus >= {1'b0, r_used});
        o_stat.found      = r_found;
        o_stat.mode_eq    = (r_exclude == to_excl);
        o_stat.exclude    = r_exclude;
        o_stat.full       = (r_used == FC_W'(FILTER_ENTRIES));
        o_stat.ring_empty = (r_count == '0);
        o_stat.k_last     = ((r_k + 1'b1) == r_count);
        o_stat.rec_match  = rec_match;
        o_stat.pend_v     = r_pend_v;
        o_stat.out_busy   = out_busy;
    end

    `FTRB_ASSERT(a_count_max, (r_count <= RC_W'(RECORD_DEPTH)), "ring count above depth")
    `FTRB_ASSERT(a_used_max, (r_used <= FC_W'(FILTER_ENTRIES)), "filter list overfull")
    `FTRB_ASSERT(a_empty_head, ((r_count == '0) |-> (r_head == '0)), "empty ring with head set")
    `FTRB_ASSERT_NEXT(a_total_inc, i_cmd.rec_wr, (r_total == $past(r_total) + 1'b1), "total missed")
endmodule

`default_nettype wire

FILE: hw/rtl/filtered_trace_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// filtered_trace_ring_buffer_core
// Process-state trace ring with a pid include/exclude filter.
// ----------------------------------------------------------------------------
// One request word at a time is taken; ready drops until its work is done.
// A record event or filter change searches the filter list entry by entry,
// and a removal or full-list add then shifts the later entries down one by
// one, since the list RAM has one registered read port. A read or clear walks
// the ring record by record; a read stalls while the result word waits to be
// taken. Stores start undefined and need no clearing pass after reset.
`default_nettype none

module filtered_trace_ring_buffer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ftrb_in_if.sink    i_in,
    ftrb_out_if.source o_out
);
    import ftrb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ftrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ftrb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire

FILE: sim/tb_filtered_trace_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// tb_filtered_trace_ring_buffer_core
// Random and directed test of the filtered trace ring with a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_filtered_trace_ring_buffer_core;
    import ftrb_pkg::*;

    typedef struct {
        logic                    has_record;
        logic signed [PID_W-1:0] pid;
        logic [STATE_W-1:0]      state;
        logic [NAME_W-1:0]       name_low;
        logic [NAME_W-1:0]       name_high;
        logic                    last;
        logic [TOTAL_W-1:0]      total;
    } t_result;

    class trace_scoreboard;
        bit                      exclude_mode;
        int                      filter_list[$];
        t_rec                    ring[$];
        logic [TOTAL_W-1:0]      total;
        t_result                 pending[$];
        int                      errors;

        function void note_word(logic [ACT_W-1:0] act, logic signed [PID_W-1:0] pid_raw,
                                logic [STATE_W-1:0] ts, logic [EXIT_W-1:0] ex,
                                logic [NAME_W-1:0] nl, logic [NAME_W-1:0] nh);
            int      pid;
            int      at[$];
            t_rec    r;
            t_rec    kept[$];
            t_result res;
            bit      to_excl;
            pid = int'(pid_raw);
            case (act)
                ACT_RECORD: begin
                    if (pid >= 0) begin
                        at = filter_list.find_first_index(x) with (x == pid);
                        if ((at.size() != 0) != exclude_mode) begin
                            r.pid = pid_raw;
                            r.state = (ex == EXIT_DEAD || ex == EXIT_ZOMBIE) ? STATE_W'(ex) : ts;
                            r.name_low = nl;
                            r.name_high = nh;
                            if (ring.size() == RECORD_DEPTH) void'(ring.pop_front());
                            ring.push_back(r);
                            total = total + 1;
                        end
                    end
                end
                ACT_ENABLE, ACT_DISABLE: begin
                    to_excl = (act == ACT_ENABLE);
                    if (pid == -1) begin
                        exclude_mode = to_excl;
                        filter_list.delete();
                    end else if (pid >= 0) begin
                        at = filter_list.find_first_index(x) with (x == pid);
                        if (exclude_mode == to_excl) begin
                            if (at.size() != 0) filter_list.delete(at[0]);
                        end else if (at.size() == 0) begin
                            if (filter_list.size() == FILTER_ENTRIES)
                                void'(filter_list.pop_front());
                            filter_list.push_back(pid);
                        end
                    end
                end
                ACT_READ: begin
                    int n;
                    n = 0;
                    foreach (ring[k]) begin
                        if (pid == -1 || int'($signed(ring[k].pid)) == pid) begin
                            res.has_record = 1'b1;
                            res.pid = ring[k].pid;
                            res.state = ring[k].state;
                            res.name_low = ring[k].name_low;
                            res.name_high = ring[k].name_high;
                            res.last = 1'b0;
                            res.total = total;
                            pending.push_back(res);
                            n++;
                        end
                    end
                    if (n == 0) begin
                        res = '{default: '0};
                        res.total = total;
                        pending.push_back(res);
                    end
                    pending[pending.size()-1].last = 1'b1;
                end
                ACT_CLEAR: begin
                    if (pid == -1) ring.delete();
                    else if (pid >= 0) begin
                        foreach (ring[k])
                            if (int'($signed(ring[k].pid)) != pid) kept.push_back(ring[k]);
                        ring = kept;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result word pid=%0d", got.pid);
                return;
            end
            want = pending.pop_front();
            if (got.has_record !== want.has_record || got.pid !== want.pid ||
                got.state !== want.state || got.name_low !== want.name_low ||
                got.name_high !== want.name_high || got.last !== want.last ||
                got.total !== want.total) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp rec=%0b pid=%0d st=%h n=%h_%h last=%0b tot=%0d",
                        want.has_record, want.pid, want.state, want.name_high,
                        want.name_low, want.last, want.total,
                        " / got rec=%0b pid=%0d st=%h n=%h_%h last=%0b tot=%0d",
                        got.has_record, got.pid, got.state, got.name_high,
                        got.name_low, got.last, got.total);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ftrb_in_if  req_if ();
    ftrb_out_if res_if ();

    filtered_trace_ring_buffer_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if.sink),
        .o_out  (res_if.source)
    );

    trace_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  pid_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // accepted words on both channels, plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_word(req_if.action, req_if.pid, req_if.task_state,
                             req_if.exit_code_state, req_if.name_low, req_if.name_high);
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_word('{res_if.has_record, res_if.rec_pid, res_if.rec_state,
                    res_if.rec_name_low, res_if.rec_name_high, res_if.last,
                    res_if.total_seen});
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver side
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_word(logic [ACT_W-1:0] act, logic signed [PID_W-1:0] pid,
                             logic [STATE_W-1:0] ts, logic [EXIT_W-1:0] ex,
                             logic [NAME_W-1:0] nl, logic [NAME_W-1:0] nh);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.action          <= act;
        req_if.pid             <= pid;
        req_if.task_state      <= ts;
        req_if.exit_code_state <= ex;
        req_if.name_low        <= nl;
        req_if.name_high       <= nh;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_simple(logic [ACT_W-1:0] act, int pid);
        send_word(act, PID_W'(pid), 16'($urandom), 6'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic send_random();
        int sel;
        int pid;
        logic [EXIT_W-1:0] ex;
        sel = $urandom_range(99);
        pid = (sel % 10 == 0) ? -1 : pid_pool[$urandom_range(7)];
        if ($urandom_range(19) == 0) pid = $urandom_range(4194303);
        if ($urandom_range(29) == 0) pid = -int'($urandom_range(4194304, 2));
        ex = ($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? EXIT_DEAD : EXIT_ZOMBIE)
                                      : 6'($urandom);
        if (sel < 55)
            send_word(ACT_RECORD, PID_W'(pid), 16'($urandom), ex,
                      {$urandom, $urandom}, {$urandom, $urandom});
        else if (sel < 68) send_simple(ACT_ENABLE, pid);
        else if (sel < 80) send_simple(ACT_DISABLE, pid);
        else if (sel < 92) send_simple(ACT_READ, pid);
        else if (sel < 97) send_simple(ACT_CLEAR, pid);
        else send_simple(ACT_W'($urandom_range(7, 5)), pid);
    endtask

    initial begin
        sb = new();
        sb.total = '0;
        sb.errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        req_if.valid = 1'b0;
        req_if.action = '0;
        req_if.pid = '0;
        req_if.task_state = '0;
        req_if.exit_code_state = '0;
        req_if.name_low = '0;
        req_if.name_high = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        foreach (pid_pool[k]) pid_pool[k] = $urandom_range(4194303);
        pid_pool[0] = 0;
        pid_pool[1] = 4194303;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty reads, extremes, both exit overrides, filter modes
        send_simple(ACT_READ, -1);
        send_simple(ACT_RECORD, 5);              // include mode, empty list: dropped
        send_simple(ACT_ENABLE, 0);
        send_simple(ACT_ENABLE, 4194303);
        send_word(ACT_RECORD, PID_W'(0), 16'hFFFF, 6'd0, '1, '1);
        send_word(ACT_RECORD, 23'sd4194303, 16'h0000, EXIT_DEAD, '0, '0);
        send_word(ACT_RECORD, PID_W'(0), 16'h1234, EXIT_ZOMBIE, 64'h0123456789ABCDEF, '1);
        send_word(ACT_RECORD, PID_W'(-1), 16'h1, 6'h3F, '1, '0);
        send_simple(ACT_READ, 0);
        send_simple(ACT_READ, -2);
        send_simple(ACT_READ, -4194304);
        send_simple(ACT_ENABLE, -1);             // exclude mode, list emptied
        send_simple(ACT_DISABLE, 7);             // skip pid 7
        send_simple(ACT_RECORD, 7);
        send_simple(ACT_RECORD, 8);
        send_simple(ACT_ENABLE, -5);
        send_simple(ACT_CLEAR, -3);
        send_simple(ACT_CLEAR, 0);
        send_simple(ACT_READ, -1);
        send_simple(ACT_W'(5), 0);
        send_simple(ACT_W'(7), -1);
        send_simple(ACT_CLEAR, -1);
        send_simple(ACT_DISABLE, -1);
        // fill the filter past its size so the oldest entry drops
        for (int k = 0; k < FILTER_ENTRIES + 2; k++) send_simple(ACT_ENABLE, 100 + k);
        send_simple(ACT_RECORD, 100);
        send_simple(ACT_RECORD, 133);
        send_simple(ACT_READ, -1);
        send_simple(ACT_ENABLE, -1);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                3: begin send_idle_pct = 25; stall_pct = 25; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            if (ph == 4) begin
                // long receiver hold-off with reads queued behind it
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int k = 0; k < 40; k++) send_random();
                        for (int k = 0; k < 4; k++) send_simple(ACT_READ, -1);
                    end
                join
            end else begin
                for (int k = 0; k < 70; k++) send_random();
            end
        end

        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire
